// ===== rtl/fbv_pkg.sv =====
`default_nettype none
package fbv_pkg;
	localparam int EYE_BITS = 21;
	localparam int AXIS_BITS = 16;
	localparam int ACC_BITS = 58;
	localparam int CAM_BITS = 44;
	localparam int PADDR_BITS = 6;
	localparam int PDATA_BITS = 64;

	localparam logic [2:0] REG_EYE = 3'd0;
	localparam logic [2:0] REG_RIGHT = 3'd1;
	localparam logic [2:0] REG_UP = 3'd2;
	localparam logic [2:0] REG_FWD = 3'd3;
	localparam logic [2:0] REG_DEPTH = 3'd4;
	localparam logic [2:0] REG_SLOPE = 3'd5;
	localparam logic [2:0] REG_PAD = 3'd6;

	localparam logic [5:0] ALL_OUTSIDE = 6'h3f;
	localparam logic signed [39:0] SIDE_LIMIT = 40'sd2147483647;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DOT_X = 5'b00010,
		ST_DOT_Y = 5'b00100,
		ST_DOT_Z = 5'b01000,
		ST_TEST = 5'b10000
	} state_t;

	typedef struct packed {
		logic load;
		logic [1:0] axis_sel;
		logic dot_en;
		logic test_en;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic visible;
	} status_t;
endpackage
`default_nettype wire

// ===== rtl/fbv_if.sv =====
`default_nettype none
interface fbv_corner_if #(parameter int COORD_BITS = 21);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] corner_x;
	logic signed [COORD_BITS-1:0] corner_y;
	logic signed [COORD_BITS-1:0] corner_z;
	logic last_corner;
	logic bounds_unknown;
	modport source (output valid, corner_x, corner_y, corner_z, last_corner, bounds_unknown,
		input ready);
	modport sink (input valid, corner_x, corner_y, corner_z, last_corner, bounds_unknown,
		output ready);
endinterface

interface fbv_result_if;
	logic valid;
	logic ready;
	logic visible;
	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface
`default_nettype wire

// ===== rtl/frustum_box_visibility.sv =====
`default_nettype none
// a corner is taken only in idle; the shared three-term dot product unit runs
// once per camera axis (right, up, forward), then the plane test runs, and on the
// last corner the result valid is registered at the end of the test; after a last
// corner the next transfer also waits for the result transfer
// reset: arst_n clears config and control registers, outside flags to all ones
// and drops output valid; box bounds and camera coordinates are not reset
module frustum_box_visibility #(
	parameter int COORD_BITS = 21
) (
	input wire logic clk,
	input wire logic arst_n,
	fbv_corner_if.sink corner,
	fbv_result_if.source result,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [fbv_pkg::PADDR_BITS-1:0] paddr,
	input wire logic [fbv_pkg::PDATA_BITS-1:0] pwdata,
	output logic [fbv_pkg::PDATA_BITS-1:0] prdata,
	output logic pready
);
	// config registers, 8 byte stride
	logic [62:0] eye_q, pad_q;
	logic [47:0] right_q, up_q, fwd_q;
	logic [61:0] depth_q, slope_q;
	logic [2:0] idx;
	logic wr;

	assign pready = 1'b1;
	assign idx = paddr[5:3];
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_q <= '0; right_q <= '0; up_q <= '0; fwd_q <= '0;
			depth_q <= '0; slope_q <= '0; pad_q <= '0;
		end else if (wr) begin
			case (idx)
				fbv_pkg::REG_EYE: eye_q <= pwdata[62:0];
				fbv_pkg::REG_RIGHT: right_q <= pwdata[47:0];
				fbv_pkg::REG_UP: up_q <= pwdata[47:0];
				fbv_pkg::REG_FWD: fwd_q <= pwdata[47:0];
				fbv_pkg::REG_DEPTH: depth_q <= pwdata[61:0];
				fbv_pkg::REG_SLOPE: slope_q <= pwdata[61:0];
				fbv_pkg::REG_PAD: pad_q <= pwdata[62:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			fbv_pkg::REG_EYE: prdata = {1'b0, eye_q};
			fbv_pkg::REG_RIGHT: prdata = {16'd0, right_q};
			fbv_pkg::REG_UP: prdata = {16'd0, up_q};
			fbv_pkg::REG_FWD: prdata = {16'd0, fwd_q};
			fbv_pkg::REG_DEPTH: prdata = {2'd0, depth_q};
			fbv_pkg::REG_SLOPE: prdata = {2'd0, slope_q};
			fbv_pkg::REG_PAD: prdata = {1'b0, pad_q};
			default: prdata = '0;
		endcase
	end

	fbv_pkg::cmd_t cmd;
	fbv_pkg::status_t status;

	// sequencer: load, three dot products, plane test
	fbv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(corner.valid), .in_ready(corner.ready),
		.out_valid(result.valid), .out_ready(result.ready),
		.status(status), .cmd(cmd), .out_visible(result.visible)
	);

	fbv_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.corner_x(corner.corner_x), .corner_y(corner.corner_y),
		.corner_z(corner.corner_z), .last_corner(corner.last_corner),
		.bounds_unknown(corner.bounds_unknown),
		.eye_position(eye_q), .right_axis(right_q), .up_axis(up_q),
		.forward_axis(fwd_q), .depth_range(depth_q),
		.frustum_slopes(slope_q), .padding_terms(pad_q)
	);
endmodule
`default_nettype wire

// ===== rtl/fbv_ctrl.sv =====
`default_nettype none
module fbv_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire fbv_pkg::status_t status,
	output fbv_pkg::cmd_t cmd,
	output logic out_visible
);
	fbv_pkg::state_t state_q;
	logic out_valid_q;
	logic vis_q;

	assign in_ready = (state_q == fbv_pkg::ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_visible = vis_q;

	always_comb begin
		cmd.load = in_valid && in_ready;
		cmd.dot_en = 1'b0;
		cmd.axis_sel = 2'd0;
		cmd.test_en = 1'b0;
		case (state_q)
			fbv_pkg::ST_DOT_X: begin cmd.dot_en = 1'b1; cmd.axis_sel = 2'd0; end
			fbv_pkg::ST_DOT_Y: begin cmd.dot_en = 1'b1; cmd.axis_sel = 2'd1; end
			fbv_pkg::ST_DOT_Z: begin cmd.dot_en = 1'b1; cmd.axis_sel = 2'd2; end
			fbv_pkg::ST_TEST: cmd.test_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbv_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			vis_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				fbv_pkg::ST_IDLE: if (cmd.load) state_q <= fbv_pkg::ST_DOT_X;
				fbv_pkg::ST_DOT_X: state_q <= fbv_pkg::ST_DOT_Y;
				fbv_pkg::ST_DOT_Y: state_q <= fbv_pkg::ST_DOT_Z;
				fbv_pkg::ST_DOT_Z: state_q <= fbv_pkg::ST_TEST;
				fbv_pkg::ST_TEST: begin
					state_q <= fbv_pkg::ST_IDLE;
					if (status.last) begin
						out_valid_q <= 1'b1;
						vis_q <= status.visible;
					end
				end
				default: state_q <= fbv_pkg::ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/fbv_datapath.sv =====
`default_nettype none
module fbv_datapath #(
	parameter int COORD_BITS = 21
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire fbv_pkg::cmd_t cmd,
	output fbv_pkg::status_t status,
	input wire logic signed [COORD_BITS-1:0] corner_x,
	input wire logic signed [COORD_BITS-1:0] corner_y,
	input wire logic signed [COORD_BITS-1:0] corner_z,
	input wire logic last_corner,
	input wire logic bounds_unknown,
	input wire logic [62:0] eye_position,
	input wire logic [47:0] right_axis,
	input wire logic [47:0] up_axis,
	input wire logic [47:0] forward_axis,
	input wire logic [61:0] depth_range,
	input wire logic [61:0] frustum_slopes,
	input wire logic [62:0] padding_terms
);
	localparam int WB = (COORD_BITS > fbv_pkg::EYE_BITS) ? COORD_BITS : fbv_pkg::EYE_BITS;
	localparam int RB = WB + 1;
	localparam int IB = WB + 2;
	localparam int PB = RB + fbv_pkg::AXIS_BITS;

	logic signed [COORD_BITS-1:0] mn_q [3];
	logic signed [COORD_BITS-1:0] mx_q [3];
	logic signed [RB-1:0] rel_q [3];
	logic signed [fbv_pkg::CAM_BITS-1:0] x_q, y_q, z_q;
	logic [5:0] flags_q;
	logic unk_q, first_q, last_q;

	logic signed [fbv_pkg::EYE_BITS-1:0] eye [3];
	logic signed [COORD_BITS-1:0] cin [3];
	logic [47:0] axis;
	logic signed [PB-1:0] prod [3];
	logic signed [fbv_pkg::ACC_BITS-1:0] acc;
	logic signed [fbv_pkg::CAM_BITS-1:0] cam;

	assign cin[0] = corner_x;
	assign cin[1] = corner_y;
	assign cin[2] = corner_z;
	assign eye[0] = eye_position[20:0];
	assign eye[1] = eye_position[41:21];
	assign eye[2] = eye_position[62:42];

	always_comb begin
		case (cmd.axis_sel)
			2'd0: axis = right_axis;
			2'd1: axis = up_axis;
			default: axis = forward_axis;
		endcase
		acc = fbv_pkg::ACC_BITS'(16'sd8192);
		for (int i = 0; i < 3; i++) begin
			prod[i] = PB'(rel_q[i]) * PB'($signed(axis[16*i +: 16]));
			acc = acc + fbv_pkg::ACC_BITS'(prod[i]);
		end
		cam = fbv_pkg::CAM_BITS'(acc >>> 14);
	end

	// tests on registered camera coordinates
	logic signed [32:0] nearp, farp;
	logic [30:0] tx, ty;
	logic [20:0] pad, px, py;
	logic signed [39:0] sx, sy, sz;
	logic signed [31:0] sz32, tx32, ty32;
	logic signed [63:0] zx_m, zy_m;
	logic signed [fbv_pkg::CAM_BITS+1:0] zc;
	logic signed [72:0] zx, zy, sx24, sy24, nx, ny;
	logic [5:0] f;
	logic eye_in_box;

	function automatic logic signed [39:0] sat(input logic signed [fbv_pkg::CAM_BITS-1:0] v);
		logic signed [39:0] r;
		if (v > fbv_pkg::CAM_BITS'(fbv_pkg::SIDE_LIMIT)) r = fbv_pkg::SIDE_LIMIT;
		else if (v < -fbv_pkg::CAM_BITS'(fbv_pkg::SIDE_LIMIT)) r = -fbv_pkg::SIDE_LIMIT;
		else r = 40'(v);
		return r;
	endfunction

	always_comb begin
		nearp = 33'($signed(depth_range[30:0]));
		farp = 33'($signed(depth_range[61:31]));
		tx = frustum_slopes[30:0];
		ty = frustum_slopes[61:31];
		pad = padding_terms[20:0];
		px = padding_terms[41:21];
		py = padding_terms[62:42];
		sx = sat(x_q);
		sy = sat(y_q);
		sz = sat(z_q);
		zc = (fbv_pkg::CAM_BITS+2)'(z_q);
		// saturated z fits 32 bits, so the slope products stay 32 by 32
		sz32 = sz[31:0];
		tx32 = $signed({1'b0, tx});
		ty32 = $signed({1'b0, ty});
		zx_m = sz32 * tx32;
		zy_m = sz32 * ty32;
		zx = 73'(zx_m);
		zy = 73'(zy_m);
		sx24 = 73'(sx) <<< 24;
		sy24 = 73'(sy) <<< 24;
		nx = -(73'($signed({1'b0, px})) <<< 24);
		ny = -(73'($signed({1'b0, py})) <<< 24);
		f[0] = zc < (fbv_pkg::CAM_BITS+2)'(nearp) - (fbv_pkg::CAM_BITS+2)'($signed({1'b0, pad}));
		f[1] = zc > (fbv_pkg::CAM_BITS+2)'(farp) + (fbv_pkg::CAM_BITS+2)'($signed({1'b0, pad}));
		f[2] = zx + sx24 < nx;
		f[3] = zx - sx24 < nx;
		f[4] = zy + sy24 < ny;
		f[5] = zy - sy24 < ny;
		eye_in_box = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (IB'(eye[i]) < IB'(mn_q[i]) - IB'($signed({1'b0, pad}))
				|| IB'(eye[i]) > IB'(mx_q[i]) + IB'($signed({1'b0, pad})))
				eye_in_box = 1'b0;
		end
		status.last = last_q;
		status.visible = unk_q || eye_in_box || (tx == '0) || (ty == '0)
			|| ((flags_q & f) == 6'd0);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				rel_q[i] <= RB'(cin[i]) - RB'(eye[i]);
				if (first_q || cin[i] < mn_q[i]) mn_q[i] <= cin[i];
				if (first_q || cin[i] > mx_q[i]) mx_q[i] <= cin[i];
			end
			last_q <= last_corner;
		end
		if (cmd.dot_en) begin
			case (cmd.axis_sel)
				2'd0: x_q <= cam;
				2'd1: y_q <= cam;
				default: z_q <= cam;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= fbv_pkg::ALL_OUTSIDE;
			unk_q <= 1'b0;
			first_q <= 1'b1;
		end else begin
			if (cmd.load) begin
				first_q <= 1'b0;
				if (bounds_unknown) unk_q <= 1'b1;
			end
			if (cmd.test_en) begin
				if (last_q) begin
					flags_q <= fbv_pkg::ALL_OUTSIDE;
					unk_q <= 1'b0;
					first_q <= 1'b1;
				end else begin
					flags_q <= flags_q & f;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/fbv_checker.sv =====
`default_nettype none
module fbv_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_visible,
	input wire logic pready
);
	a_ready_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after transfer");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_visible))
		else $error("result dropped");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while result waits");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind frustum_box_visibility fbv_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(corner.valid), .in_ready(corner.ready),
	.out_valid(result.valid), .out_ready(result.ready),
	.out_visible(result.visible), .pready(pready)
);
`default_nettype wire
